// ===== hdl/sbrp_pkg.sv =====
// Shared constants, result codes and request/state structs for the
// STUN binding response parser. No dependencies.
`timescale 1ns / 1ps

package sbrp_pkg;

  localparam int unsigned COUNT_W = 17;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;
  localparam logic [COUNT_W-1:0] HDR_LEN = 17'd20;

  localparam logic [7:0]  MSG_TYPE_BYTE = 8'h01;
  localparam logic [31:0] MAGIC = 32'h2112A442;
  localparam logic [15:0] TYPE_XOR = 16'h0020;
  localparam logic [15:0] TYPE_PLAIN = 16'h0001;
  localparam logic [7:0]  FAMILY_IPV4 = 8'h01;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TXID_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TXID_LOW = 2'd1;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_SHORT = 3'd1;
  localparam logic [2:0] ST_NOT_SUCCESS = 3'd2;
  localparam logic [2:0] ST_ID_MISMATCH = 3'd3;
  localparam logic [2:0] ST_TRUNCATED = 3'd4;
  localparam logic [2:0] ST_NO_ADDR = 3'd5;

  // One accepted datagram byte.
  typedef struct packed {
    logic               take;
    logic               last;
    logic [7:0]         data;
    logic [COUNT_W-1:0] index;
  } sbrp_byte_t;

  // Header check results after the current byte.
  typedef struct packed {
    logic        type_ok;
    logic        cookie_ok;
    logic        id_ok;
    logic [15:0] msg_len;
  } sbrp_hdr_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] port;
    logic [31:0] addr;
  } sbrp_ep_t;

  // Endpoints found so far, including the current byte.
  typedef struct packed {
    sbrp_ep_t xor_ep;
    sbrp_ep_t plain_ep;
  } sbrp_walk_t;

endpackage

// ===== hdl/sbrp_hdr_check.sv =====
// Header checker: message type, magic cookie, transaction id, length.
// Depends on sbrp_pkg.
`timescale 1ns / 1ps

module sbrp_hdr_check import sbrp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  sbrp_byte_t  req,
  input  logic [31:0] txid_high,
  input  logic [63:0] txid_low,
  output sbrp_hdr_t   hdr_next
);

  sbrp_hdr_t hdr;
  logic [7:0] want;
  logic       id_byte;

  // Expected id byte for header offsets 8..19.
  always_comb begin
    want = 8'h00;
    id_byte = 1'b0;
    unique case (req.index[4:0])
      5'd8:  begin want = txid_high[31:24]; id_byte = 1'b1; end
      5'd9:  begin want = txid_high[23:16]; id_byte = 1'b1; end
      5'd10: begin want = txid_high[15:8];  id_byte = 1'b1; end
      5'd11: begin want = txid_high[7:0];   id_byte = 1'b1; end
      5'd12: begin want = txid_low[63:56];  id_byte = 1'b1; end
      5'd13: begin want = txid_low[55:48];  id_byte = 1'b1; end
      5'd14: begin want = txid_low[47:40];  id_byte = 1'b1; end
      5'd15: begin want = txid_low[39:32];  id_byte = 1'b1; end
      5'd16: begin want = txid_low[31:24];  id_byte = 1'b1; end
      5'd17: begin want = txid_low[23:16];  id_byte = 1'b1; end
      5'd18: begin want = txid_low[15:8];   id_byte = 1'b1; end
      5'd19: begin want = txid_low[7:0];    id_byte = 1'b1; end
      default: begin want = 8'h00; id_byte = 1'b0; end
    endcase
  end

  always_comb begin
    hdr_next = hdr;
    if (req.index < HDR_LEN) begin
      unique case (req.index[4:0])
        5'd0, 5'd1: begin
          if (req.data != MSG_TYPE_BYTE) hdr_next.type_ok = 1'b0;
        end
        5'd2: hdr_next.msg_len = {req.data, 8'h00};
        5'd3: hdr_next.msg_len = {hdr.msg_len[15:8], req.data};
        5'd4: if (req.data != MAGIC[31:24]) hdr_next.cookie_ok = 1'b0;
        5'd5: if (req.data != MAGIC[23:16]) hdr_next.cookie_ok = 1'b0;
        5'd6: if (req.data != MAGIC[15:8])  hdr_next.cookie_ok = 1'b0;
        5'd7: if (req.data != MAGIC[7:0])   hdr_next.cookie_ok = 1'b0;
        default: begin
          if (id_byte && req.data != want) hdr_next.id_ok = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr <= '{type_ok: 1'b1, cookie_ok: 1'b1, id_ok: 1'b1, msg_len: 16'h0000};
    end else if (req.take) begin
      if (req.last) begin
        hdr <= '{type_ok: 1'b1, cookie_ok: 1'b1, id_ok: 1'b1, msg_len: 16'h0000};
      end else begin
        hdr <= hdr_next;
      end
    end
  end

endmodule

// ===== hdl/sbrp_attr_walk.sv =====
// Attribute walker: follows padded attributes inside the declared length
// and decodes IPv4 mapped endpoints. Depends on sbrp_pkg.
`timescale 1ns / 1ps

module sbrp_attr_walk import sbrp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  sbrp_byte_t  req,
  input  logic [15:0] msg_len,
  output sbrp_walk_t  walk_next
);

  logic [COUNT_W-1:0] attr_start, attr_start_next;
  logic [15:0]        attr_type_reg, attr_type_reg_next;
  logic [15:0]        attr_len_reg, attr_len_reg_next;
  logic               attr_family_ok, attr_family_ok_next;
  logic               walk_stopped, walk_stopped_next;
  logic [47:0]        value_shift, value_shift_next;
  sbrp_walk_t         walk;

  logic [COUNT_W-1:0] end_pos;
  logic [COUNT_W-1:0] rel;
  logic               active;
  logic               overrun;
  logic [COUNT_W:0]   span;
  logic [COUNT_W:0]   padded;
  logic [COUNT_W:0]   next_start;
  logic               is_xor;
  logic [15:0]        dec_port;
  logic [31:0]        dec_addr;

  assign end_pos = HDR_LEN + {1'b0, msg_len};
  assign active = !walk_stopped && req.index >= HDR_LEN && req.index < end_pos &&
                  req.index >= attr_start;
  assign rel = req.index - attr_start;
  assign is_xor = attr_type_reg == TYPE_XOR;

  always_comb begin
    attr_start_next = attr_start;
    attr_type_reg_next = attr_type_reg;
    attr_len_reg_next = attr_len_reg;
    attr_family_ok_next = attr_family_ok;
    walk_stopped_next = walk_stopped;
    value_shift_next = value_shift;
    walk_next = walk;
    overrun = 1'b0;
    span = '0;
    padded = '0;
    next_start = '0;
    dec_port = 16'h0000;
    dec_addr = 32'h0000_0000;
    if (active) begin
      if (rel == 17'd0) begin
        attr_type_reg_next = {req.data, 8'h00};
      end else if (rel == 17'd1) begin
        attr_type_reg_next = {attr_type_reg[15:8], req.data};
      end else if (rel == 17'd2) begin
        attr_len_reg_next = {req.data, 8'h00};
      end else if (rel == 17'd3) begin
        attr_len_reg_next = {attr_len_reg[15:8], req.data};
        span = {1'b0, attr_start} + 18'd4 + {2'b00, attr_len_reg_next};
        if (span > {1'b0, end_pos}) begin
          overrun = 1'b1;
          walk_stopped_next = 1'b1;
        end
      end else if (rel == 17'd5) begin
        attr_family_ok_next = req.data == FAMILY_IPV4;
      end else if (rel >= 17'd6 && rel <= 17'd11) begin
        value_shift_next = {value_shift[39:0], req.data};
        if (rel == 17'd11 && attr_len_reg >= 16'd8 && attr_family_ok &&
            (is_xor || attr_type_reg == TYPE_PLAIN)) begin
          dec_port = value_shift_next[47:32] ^ (is_xor ? MAGIC[31:16] : 16'h0000);
          dec_addr = value_shift_next[31:0] ^ (is_xor ? MAGIC : 32'h0000_0000);
          if (dec_port != 16'h0000) begin
            if (is_xor) begin
              if (!walk.xor_ep.valid) begin
                walk_next.xor_ep = '{valid: 1'b1, port: dec_port, addr: dec_addr};
              end
            end else begin
              walk_next.plain_ep = '{valid: 1'b1, port: dec_port, addr: dec_addr};
            end
          end
        end
      end
      // advance to the next attribute after its last padded byte
      if (rel >= 17'd3 && !overrun) begin
        padded = ({2'b00, attr_len_reg_next} + 18'd3) & ~18'd3;
        next_start = {1'b0, attr_start} + 18'd4 + padded;
        if ({1'b0, req.index} + 18'd1 == next_start) begin
          attr_start_next = next_start[COUNT_W-1:0];
          attr_family_ok_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (req.take && req.last)) begin
      attr_start <= HDR_LEN;
      attr_type_reg <= 16'h0000;
      attr_len_reg <= 16'h0000;
      attr_family_ok <= 1'b0;
      walk_stopped <= 1'b0;
      value_shift <= 48'h0;
      walk <= '0;
    end else if (req.take) begin
      attr_start <= attr_start_next;
      attr_type_reg <= attr_type_reg_next;
      attr_len_reg <= attr_len_reg_next;
      attr_family_ok <= attr_family_ok_next;
      walk_stopped <= walk_stopped_next;
      value_shift <= value_shift_next;
      walk <= walk_next;
    end
  end

endmodule

// ===== hdl/sbrp_result.sv =====
// Result stage: status priority, endpoint selection and the output register.
// Depends on sbrp_pkg.
`timescale 1ns / 1ps

module sbrp_result import sbrp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  sbrp_byte_t         req,
  input  logic [COUNT_W-1:0] size,
  input  sbrp_hdr_t          hdr_next,
  input  sbrp_walk_t         walk_next,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [2:0]         status,
  output logic [31:0]        mapped_ipv4,
  output logic [15:0]        mapped_port,
  output logic               from_xor
);

  logic [2:0]  st;
  sbrp_ep_t    ep;
  logic        ep_xor;
  logic [COUNT_W-1:0] frame_end;

  assign frame_end = HDR_LEN + {1'b0, hdr_next.msg_len};

  always_comb begin
    ep = '0;
    ep_xor = 1'b0;
    priority if (size < HDR_LEN) begin
      st = ST_SHORT;
    end else if (!hdr_next.type_ok || !hdr_next.cookie_ok) begin
      st = ST_NOT_SUCCESS;
    end else if (!hdr_next.id_ok) begin
      st = ST_ID_MISMATCH;
    end else if (size < frame_end) begin
      st = ST_TRUNCATED;
    end else if (walk_next.xor_ep.valid) begin
      st = ST_OK;
      ep = walk_next.xor_ep;
      ep_xor = 1'b1;
    end else if (walk_next.plain_ep.valid) begin
      st = ST_OK;
      ep = walk_next.plain_ep;
    end else begin
      st = ST_NO_ADDR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req.take && req.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.take && req.last) begin
      status <= st;
      mapped_ipv4 <= ep.addr;
      mapped_port <= ep.port;
      from_xor <= ep_xor;
    end
  end

endmodule

// ===== hdl/stun_binding_response_parser_core.sv =====
// Top level of the STUN binding response parser (IPv4 mapped endpoint).
// Depends on sbrp_pkg, sbrp_hdr_check, sbrp_attr_walk, sbrp_result.
`timescale 1ns / 1ps
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_ready  | data_byte[7:0], last_byte
//  out     | out_valid / out_ready| status[2:0], mapped_ipv4[31:0],
//          |                      | mapped_port[15:0], from_xor
//  cfg     | cfg_valid / cfg_ready| cfg_index[1:0], cfg_data[63:0]
//
// One byte per cycle while in_ready is high. A byte request updates the per-datagram state in the
// cycle it is taken; a byte with last_byte set loads the result register, and
// out_valid rises on the next cycle.
// in_ready drops only while a result sits unread in the output register.
// rst is synchronous: clears counters, header flags, walker state, endpoints,
// txid registers and the output valid. cfg_ready is always high.

module stun_binding_response_parser_core import sbrp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           status,
  output logic [31:0]          mapped_ipv4,
  output logic [15:0]          mapped_port,
  output logic                 from_xor,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  logic [31:0]        txid_high;
  logic [63:0]        txid_low;
  logic [COUNT_W-1:0] byte_count, byte_count_next;
  sbrp_byte_t         req;
  sbrp_hdr_t          hdr_next;
  sbrp_walk_t         walk_next;

  // Output register frees up whenever the consumer takes the pending result.
  assign in_ready = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  assign req = '{take: in_valid && in_ready, last: last_byte, data: data_byte,
                 index: byte_count};

  // Saturating byte index; the count after this byte is the datagram size.
  assign byte_count_next = (byte_count == COUNT_MAX) ? byte_count :
                           byte_count + 17'd1;

  always_ff @(posedge clk) begin
    if (rst || (req.take && req.last)) begin
      byte_count <= '0;
    end else if (req.take) begin
      byte_count <= byte_count_next;
    end
  end

  // Expected transaction id; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      txid_high <= 32'h0;
      txid_low <= 64'h0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_TXID_HIGH) txid_high <= cfg_data[31:0];
      if (cfg_index == CFG_TXID_LOW) txid_low <= cfg_data;
    end
  end

  sbrp_hdr_check u_hdr (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .txid_high (txid_high),
    .txid_low  (txid_low),
    .hdr_next  (hdr_next)
  );

  sbrp_attr_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .msg_len   (hdr_next.msg_len),
    .walk_next (walk_next)
  );

  sbrp_result u_result (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .size        (byte_count_next),
    .hdr_next    (hdr_next),
    .walk_next   (walk_next),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .status      (status),
    .mapped_ipv4 (mapped_ipv4),
    .mapped_port (mapped_port),
    .from_xor    (from_xor)
  );

endmodule

// ===== hdl/sbrp_checker.sv =====
// Port-level checks for the STUN binding response parser, bound to the top.
// Depends on sbrp_pkg and stun_binding_response_parser_core.
`timescale 1ns / 1ps

module sbrp_checker import sbrp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        last_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [31:0] mapped_ipv4,
  input logic [15:0] mapped_port,
  input logic        from_xor
);

  // a last byte always produces a result on the next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_byte |=> out_valid)
    else $error("last byte did not produce a result");

  // failed datagrams report a zero endpoint
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |->
      mapped_ipv4 == 32'h0 && mapped_port == 16'h0 && !from_xor)
    else $error("endpoint not zero on failure status");

  // a reported endpoint never has port zero
  a_ok_port: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> mapped_port != 16'h0)
    else $error("ok status with zero port");

  // a held result stays unchanged
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(status) && $stable(mapped_ipv4) &&
      $stable(mapped_port) && $stable(from_xor))
    else $error("stalled result changed");

endmodule

bind stun_binding_response_parser_core sbrp_checker u_sbrp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .last_byte   (last_byte),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .mapped_ipv4 (mapped_ipv4),
  .mapped_port (mapped_port),
  .from_xor    (from_xor)
);
